### hw/rtl/sfd_pkg.sv
// Shared types and constants for the serial frame deframer with CRC-16 check.
// No dependencies.
package sfd_pkg;

    localparam int unsigned MAX_PAD_BYTES = 4;
    localparam int unsigned PAD_CAP_INT   = (MAX_PAD_BYTES < 4) ? MAX_PAD_BYTES : 4;
    localparam logic [2:0]  PAD_CAP       = 3'(PAD_CAP_INT);

    localparam logic [15:0] CRC_POLY      = 16'h1021;

    localparam logic [2:0] CFG_PAD_LENGTH    = 3'd0;
    localparam logic [2:0] CFG_PAD_PATTERN   = 3'd1;
    localparam logic [2:0] CFG_HEADER_LENGTH = 3'd2;
    localparam logic [2:0] CFG_CHECK_LENGTH  = 3'd3;
    localparam logic [2:0] CFG_EOH_BYTE      = 3'd4;
    localparam logic [2:0] CFG_EOP_BYTE      = 3'd5;

    typedef enum logic [2:0] {
        PH_SEARCH  = 3'd0,
        PH_HEADER  = 3'd1,
        PH_EOH     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_EOP     = 3'd4,
        PH_CHECK   = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        KIND_DROP    = 3'd0,
        KIND_PAD     = 3'd1,
        KIND_HEADER  = 3'd2,
        KIND_EOH     = 3'd3,
        KIND_PAYLOAD = 3'd4,
        KIND_EOP     = 3'd5,
        KIND_CHECK   = 3'd6
    } t_kind;

endpackage

### hw/rtl/serial_frame_deframer_crc16.sv
// An accepted byte is held in the input register and then moves to the result register,
// from which it is shown as a result; a stall on i_out_ready can hold it in between.
// Throughput: one byte per cycle; input register and result register each let
// a transfer through while the next one is taken, so stalls only come from i_out_ready.
// Reset (synchronous, active low): phase to padding search, counters and CRC to
// zero, configuration to its defaults, both pipeline registers empty. Depends on sfd_pkg.
module serial_frame_deframer_crc16 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_byte_out,
    output logic [2:0]  o_byte_kind,
    output logic        o_frame_done,
    output logic        o_frame_good,
    output logic        o_frame_abort,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import sfd_pkg::*;

    function automatic logic [15:0] f_crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [2:0] f_clamp(input logic [2:0] v, input logic [2:0] hi);
        logic [2:0] r;
        r = v;
        if (v == 3'd0) begin
            r = 3'd1;
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

    // configuration
    logic [2:0]  r_pad_length;
    logic [31:0] r_pad_pattern;
    logic [2:0]  r_header_length;
    logic [2:0]  r_check_length;
    logic [7:0]  r_eoh_byte;
    logic [7:0]  r_eop_byte;

    // frame state
    t_phase      r_phase, n_phase;
    logic [2:0]  r_pad_count, n_pad_count;
    logic [2:0]  r_header_count, n_header_count;
    logic [7:0]  r_payload_length, n_payload_length;
    logic [7:0]  r_payload_count, n_payload_count;
    logic [2:0]  r_check_count, n_check_count;
    logic [15:0] r_crc, n_crc;

    // pipeline
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    t_kind       r_out_kind, n_kind;
    logic        r_out_done, n_done;
    logic        r_out_good, n_good;
    logic        r_out_abort, n_abort;

    logic        w_advance;
    logic        w_fire;
    logic [2:0]  w_plen, w_hlen, w_clen;
    logic [3:0]  w_over;
    logic [7:0]  w_want;
    logic [15:0] w_crc_add;
    logic [2:0]  w_pc_inc, w_hc_inc, w_cc_inc;
    logic [7:0]  w_pay_inc;

    assign o_cfg_ready = 1'b1;
    assign w_advance   = !r_out_valid || i_out_ready;
    assign w_fire      = r_in_valid && w_advance;
    assign o_in_ready  = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad_length    <= 3'd2;
            r_pad_pattern   <= 32'd0;
            r_header_length <= 3'd2;
            r_check_length  <= 3'd2;
            r_eoh_byte      <= 8'd0;
            r_eop_byte      <= 8'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PAD_LENGTH:    r_pad_length    <= i_cfg_data[2:0];
                CFG_PAD_PATTERN:   r_pad_pattern   <= i_cfg_data;
                CFG_HEADER_LENGTH: r_header_length <= i_cfg_data[2:0];
                CFG_CHECK_LENGTH:  r_check_length  <= i_cfg_data[2:0];
                CFG_EOH_BYTE:      r_eoh_byte      <= i_cfg_data[7:0];
                CFG_EOP_BYTE:      r_eop_byte      <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign w_plen    = f_clamp(r_pad_length, PAD_CAP);
    assign w_hlen    = f_clamp(r_header_length, 3'd4);
    assign w_clen    = f_clamp(r_check_length, 3'd4);
    assign w_over    = {1'b0, w_plen} + {1'b0, w_hlen} + {1'b0, w_clen} + 4'd2;
    assign w_want    = r_pad_pattern[{r_pad_count[1:0], 3'b000} +: 8];
    assign w_crc_add = f_crc_add(r_crc, r_in_byte);
    assign w_pc_inc  = r_pad_count + 3'd1;
    assign w_hc_inc  = r_header_count + 3'd1;
    assign w_cc_inc  = r_check_count + 3'd1;
    assign w_pay_inc = r_payload_count + 8'd1;

    always_comb begin
        logic restart;
        restart          = 1'b0;
        n_phase          = r_phase;
        n_pad_count      = r_pad_count;
        n_header_count   = r_header_count;
        n_payload_length = r_payload_length;
        n_payload_count  = r_payload_count;
        n_check_count    = r_check_count;
        n_crc            = r_crc;
        n_kind           = KIND_DROP;
        n_done           = 1'b0;
        n_good           = 1'b0;
        n_abort          = 1'b0;

        case (r_phase)
            PH_SEARCH: begin
                if (r_in_byte == w_want) begin
                    n_kind = KIND_PAD;
                    n_crc  = w_crc_add;
                    if (w_pc_inc >= w_plen) begin
                        n_pad_count = 3'd0;
                        n_phase     = PH_HEADER;
                    end else begin
                        n_pad_count = w_pc_inc;
                    end
                end else begin
                    n_abort = (r_pad_count != 3'd0);
                    restart = 1'b1;
                end
            end
            PH_HEADER: begin
                if (w_hc_inc >= w_hlen) begin
                    n_kind         = KIND_HEADER;
                    n_crc          = w_crc_add;
                    n_header_count = 3'd0;
                    n_phase        = PH_EOH;
                end else if (r_in_byte <= {4'd0, w_over}) begin
                    n_abort = 1'b1;
                    restart = 1'b1;
                end else begin
                    n_kind           = KIND_HEADER;
                    n_crc            = w_crc_add;
                    n_header_count   = w_hc_inc;
                    n_payload_length = r_in_byte - {4'd0, w_over};
                end
            end
            PH_EOH: begin
                if (r_in_byte == r_eoh_byte) begin
                    n_kind          = KIND_EOH;
                    n_crc           = w_crc_add;
                    n_payload_count = 8'd0;
                    n_phase         = PH_PAYLOAD;
                end else begin
                    n_abort = 1'b1;
                    restart = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                n_kind = KIND_PAYLOAD;
                n_crc  = w_crc_add;
                if (w_pay_inc >= r_payload_length) begin
                    n_payload_count = 8'd0;
                    n_phase         = PH_EOP;
                end else begin
                    n_payload_count = w_pay_inc;
                end
            end
            PH_EOP: begin
                if (r_in_byte == r_eop_byte) begin
                    n_kind        = KIND_EOP;
                    n_crc         = w_crc_add;
                    n_check_count = 3'd0;
                    n_phase       = PH_CHECK;
                end else begin
                    n_abort = 1'b1;
                    restart = 1'b1;
                end
            end
            PH_CHECK: begin
                n_kind        = KIND_CHECK;
                n_crc         = w_crc_add;
                n_check_count = w_cc_inc;
                if (w_cc_inc >= w_clen) begin
                    n_done  = 1'b1;
                    n_good  = (w_crc_add == 16'd0);
                    restart = 1'b1;
                end
            end
            default: begin
                restart = 1'b1;
            end
        endcase

        if (restart) begin
            n_phase         = PH_SEARCH;
            n_pad_count     = 3'd0;
            n_header_count  = 3'd0;
            n_payload_count = 8'd0;
            n_check_count   = 3'd0;
            n_crc           = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_SEARCH;
            r_pad_count      <= 3'd0;
            r_header_count   <= 3'd0;
            r_payload_length <= 8'd0;
            r_payload_count  <= 8'd0;
            r_check_count    <= 3'd0;
            r_crc            <= 16'd0;
        end else if (w_fire) begin
            r_phase          <= n_phase;
            r_pad_count      <= n_pad_count;
            r_header_count   <= n_header_count;
            r_payload_length <= n_payload_length;
            r_payload_count  <= n_payload_count;
            r_check_count    <= n_check_count;
            r_crc            <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_byte  <= r_in_byte;
            r_out_kind  <= n_kind;
            r_out_done  <= n_done;
            r_out_good  <= n_good;
            r_out_abort <= n_abort;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_byte_out    = r_out_byte;
    assign o_byte_kind   = r_out_kind;
    assign o_frame_done  = r_out_done;
    assign o_frame_good  = r_out_good;
    assign o_frame_abort = r_out_abort;

endmodule

### hw/rtl/sfd_checker.sv
// Port-level checks for serial_frame_deframer_crc16, bound into that module.
// Depends on sfd_pkg.
module sfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_byte_out,
    input logic [2:0]  o_byte_kind,
    input logic        o_frame_done,
    input logic        o_frame_good,
    input logic        o_frame_abort
);
    import sfd_pkg::*;

    a_good_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_good |-> o_frame_done)
        else $error("frame_good without frame_done");

    a_done_on_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_done |-> o_byte_kind == KIND_CHECK && !o_frame_abort)
        else $error("frame end on a non-check byte");

    a_abort_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_abort |-> o_byte_kind == KIND_DROP)
        else $error("abort on a byte that was kept");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_byte_out)
            && $stable(o_byte_kind))
        else $error("stalled result transfer changed");

endmodule

bind serial_frame_deframer_crc16 sfd_checker u_sfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_byte_out    (o_byte_out),
    .o_byte_kind   (o_byte_kind),
    .o_frame_done  (o_frame_done),
    .o_frame_good  (o_frame_good),
    .o_frame_abort (o_frame_abort)
);

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for serial_frame_deframer_crc16: byte-level prediction of the deframer,
// checked in order against every result transfer. Depends on sfd_pkg and the RTL.
module tb_top;
    import sfd_pkg::*;

    localparam int RANDOM_ITEMS = 1050;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 4;
    localparam int PRINT_LIMIT  = 40;

    typedef struct {
        logic [7:0] data;
        t_kind      kind;
        logic       done;
        logic       good;
        logic       aborted;
    } t_frame_result;

    typedef enum int {
        FLAW_NONE, FLAW_CRC, FLAW_EOH, FLAW_EOP, FLAW_SHORT_LEN, FLAW_PAD, FLAW_TRUNC
    } t_flaw;

    typedef enum int {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_LONG} t_stall;

    class frame_scoreboard;
        logic [2:0]    pad_len, hdr_len, chk_len;
        logic [31:0]   pad_pat;
        logic [7:0]    eoh_mark, eop_mark;
        t_phase        ph;
        logic [2:0]    pad_cnt, hdr_cnt, chk_cnt;
        logic [7:0]    pay_len, pay_cnt;
        logic [15:0]   crc;
        t_frame_result pending_q[$];
        int            errors, bytes_seen, frames_good, frames_bad, aborts, cfg_writes;

        function new();
            pad_len  = 3'd2;
            pad_pat  = '0;
            hdr_len  = 3'd2;
            chk_len  = 3'd2;
            eoh_mark = '0;
            eop_mark = '0;
            pay_len  = '0;
            hunt_restart();
        endfunction

        function void hunt_restart();
            ph      = PH_SEARCH;
            pad_cnt = '0;
            hdr_cnt = '0;
            pay_cnt = '0;
            chk_cnt = '0;
            crc     = '0;
        endfunction

        static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] d);
            logic [15:0] r;
            r = c ^ {d, 8'h00};
            for (int i = 0; i < 8; i++)
                r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
            return r;
        endfunction

        static function logic [2:0] clamp_len(logic [2:0] v, logic [2:0] cap);
            if (v == 3'd0)
                return 3'd1;
            if (v > cap)
                return cap;
            return v;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                CFG_PAD_LENGTH:    pad_len  = val[2:0];
                CFG_PAD_PATTERN:   pad_pat  = val;
                CFG_HEADER_LENGTH: hdr_len  = val[2:0];
                CFG_CHECK_LENGTH:  chk_len  = val[2:0];
                CFG_EOH_BYTE:      eoh_mark = val[7:0];
                CFG_EOP_BYTE:      eop_mark = val[7:0];
                default: ;
            endcase
            cfg_writes++;
        endfunction

        function void note_byte(logic [7:0] rx);
            logic [2:0]    plen, hlen, clen;
            int            over;
            t_frame_result r;
            plen = clamp_len(pad_len, PAD_CAP);
            hlen = clamp_len(hdr_len, 3'd4);
            clen = clamp_len(chk_len, 3'd4);
            over = plen + hlen + clen + 2;
            r.data    = rx;
            r.kind    = KIND_DROP;
            r.done    = 1'b0;
            r.good    = 1'b0;
            r.aborted = 1'b0;
            case (ph)
                PH_SEARCH: begin
                    if (rx == pad_pat[8 * pad_cnt[1:0] +: 8]) begin
                        r.kind  = KIND_PAD;
                        crc     = crc_next(crc, rx);
                        pad_cnt = pad_cnt + 3'd1;
                        if (pad_cnt >= plen) begin
                            pad_cnt = '0;
                            ph      = PH_HEADER;
                        end
                    end else begin
                        r.aborted = (pad_cnt != 3'd0);
                        hunt_restart();
                    end
                end
                PH_HEADER: begin
                    hdr_cnt = hdr_cnt + 3'd1;
                    if (hdr_cnt >= hlen) begin
                        r.kind  = KIND_HEADER;
                        crc     = crc_next(crc, rx);
                        hdr_cnt = '0;
                        ph      = PH_EOH;
                    end else if (int'(rx) <= over) begin
                        r.aborted = 1'b1;
                        hunt_restart();
                    end else begin
                        r.kind  = KIND_HEADER;
                        crc     = crc_next(crc, rx);
                        pay_len = 8'(int'(rx) - over);
                    end
                end
                PH_EOH: begin
                    if (rx == eoh_mark) begin
                        r.kind  = KIND_EOH;
                        crc     = crc_next(crc, rx);
                        pay_cnt = '0;
                        ph      = PH_PAYLOAD;
                    end else begin
                        r.aborted = 1'b1;
                        hunt_restart();
                    end
                end
                PH_PAYLOAD: begin
                    r.kind  = KIND_PAYLOAD;
                    crc     = crc_next(crc, rx);
                    pay_cnt = pay_cnt + 8'd1;
                    if (pay_cnt >= pay_len) begin
                        pay_cnt = '0;
                        ph      = PH_EOP;
                    end
                end
                PH_EOP: begin
                    if (rx == eop_mark) begin
                        r.kind  = KIND_EOP;
                        crc     = crc_next(crc, rx);
                        chk_cnt = '0;
                        ph      = PH_CHECK;
                    end else begin
                        r.aborted = 1'b1;
                        hunt_restart();
                    end
                end
                PH_CHECK: begin
                    r.kind  = KIND_CHECK;
                    crc     = crc_next(crc, rx);
                    chk_cnt = chk_cnt + 3'd1;
                    if (chk_cnt >= clen) begin
                        r.done = 1'b1;
                        r.good = (crc == 16'h0000);
                        hunt_restart();
                    end
                end
                default: hunt_restart();
            endcase
            if (r.done && r.good)
                frames_good++;
            else if (r.done)
                frames_bad++;
            if (r.aborted)
                aborts++;
            bytes_seen++;
            pending_q.push_back(r);
        endfunction

        task report_mismatch(string what, int got, int want);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got,
                         want);
        endtask

        task check_result(t_frame_result got);
            t_frame_result want;
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected result byte_out", got.data, -1);
                return;
            end
            want = pending_q.pop_front();
            if (got.data !== want.data)
                report_mismatch("byte_out", got.data, want.data);
            if (got.kind !== want.kind)
                report_mismatch("byte_kind", got.kind, want.kind);
            if (got.done !== want.done)
                report_mismatch("frame_done", got.done, want.done);
            if (got.good !== want.good)
                report_mismatch("frame_good", got.good, want.good);
            if (got.aborted !== want.aborted)
                report_mismatch("frame_abort", got.aborted, want.aborted);
        endtask
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic [7:0]  i_rx_byte     = '0;
    logic        i_out_ready   = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic [2:0]  i_cfg_index   = '0;
    logic [31:0] i_cfg_data    = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_byte_out;
    logic [2:0]  o_byte_kind;
    logic        o_frame_done;
    logic        o_frame_good;
    logic        o_frame_abort;
    logic        o_cfg_ready;

    frame_scoreboard sb = new();
    logic [7:0]      frame_q[$];
    int              cycles, items_sent, burst_left, stall_tick, settings_used;
    bit              calm;
    t_stall          stall_mode = STALL_NONE;

    serial_frame_deframer_crc16 dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_byte_out    (o_byte_out),
        .o_byte_kind   (o_byte_kind),
        .o_frame_done  (o_frame_done),
        .o_frame_good  (o_frame_good),
        .o_frame_abort (o_frame_abort),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // receiver stall pattern, switched at random among the four stall modes
    always @(negedge i_clk) begin
        stall_tick++;
        if (stall_tick % 300 == 0)
            stall_mode = t_stall'($urandom_range(0, 3));
        case (stall_mode)
            STALL_NONE:     i_out_ready <= 1'b1;
            STALL_COIN:     i_out_ready <= ($urandom_range(0, 1) == 1);
            STALL_PERIODIC: i_out_ready <= ((stall_tick % 11) < 7);
            default:        i_out_ready <= ((stall_tick % 64) < 48);
        endcase
    end

    always @(posedge i_clk) begin : monitor
        t_frame_result got;
        if (i_rst_n) begin
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("FAILURE");
                $finish;
            end else begin
                if (i_cfg_valid && o_cfg_ready)
                    sb.write_reg(i_cfg_index, i_cfg_data);
                if (i_in_valid && o_in_ready)
                    sb.note_byte(i_rx_byte);
                if (o_out_valid && i_out_ready) begin
                    got.data    = o_byte_out;
                    got.kind    = t_kind'(o_byte_kind);
                    got.done    = o_frame_done;
                    got.good    = o_frame_good;
                    got.aborted = o_frame_abort;
                    sb.check_result(got);
                end
            end
        end
    end

    task send_byte(input logic [7:0] v);
        int gap;
        if (burst_left == 0) begin
            if (!calm) begin
                gap = $urandom_range(0, 5);
                repeat (gap) begin
                    @(negedge i_clk);
                    i_in_valid <= 1'b0;
                end
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_rx_byte  <= v;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        items_sent++;
    endtask

    task send_frame();
        while (frame_q.size() > 0)
            send_byte(frame_q.pop_front());
    endtask

    // hold off the sender until every result has come back
    task pause_until_empty();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // builds one frame for the current settings into frame_q, then spoils it as asked
    task make_frame(input int pay_n, input t_flaw flaw);
        int          plen, hlen, clen, over, n, k;
        logic [15:0] c;
        frame_q.delete();
        plen = frame_scoreboard::clamp_len(sb.pad_len, PAD_CAP);
        hlen = frame_scoreboard::clamp_len(sb.hdr_len, 3'd4);
        clen = frame_scoreboard::clamp_len(sb.chk_len, 3'd4);
        over = plen + hlen + clen + 2;
        n    = pay_n;
        if (hlen == 1)
            n = (sb.pay_len == 0) ? 1 : int'(sb.pay_len);
        else if (n > 255 - over)
            n = 255 - over;
        for (int i = 0; i < plen; i++)
            frame_q.push_back(sb.pad_pat[8 * i +: 8]);
        for (int i = 0; i < hlen - 1; i++)
            frame_q.push_back(8'((i == hlen - 2) ? over + n : $urandom_range(over + 1, 255)));
        frame_q.push_back(8'($urandom));
        frame_q.push_back(sb.eoh_mark);
        repeat (n) frame_q.push_back(8'($urandom));
        frame_q.push_back(sb.eop_mark);
        repeat (clen - 2) frame_q.push_back(8'($urandom));
        c = '0;
        foreach (frame_q[i])
            c = frame_scoreboard::crc_next(c, frame_q[i]);
        if (clen >= 2) begin
            frame_q.push_back(c[15:8]);
            frame_q.push_back(c[7:0]);
        end else begin
            frame_q.push_back(8'($urandom));
        end
        case (flaw)
            FLAW_CRC: begin
                k = frame_q.size() - 1;
                frame_q[k] = frame_q[k] ^ 8'($urandom_range(1, 255));
            end
            FLAW_EOH: frame_q[plen + hlen] = frame_q[plen + hlen] ^ 8'($urandom_range(1, 255));
            FLAW_EOP: begin
                k = plen + hlen + 1 + n;
                frame_q[k] = frame_q[k] ^ 8'($urandom_range(1, 255));
            end
            FLAW_SHORT_LEN: begin
                if (hlen > 1)
                    frame_q[plen + $urandom_range(0, hlen - 2)] = 8'($urandom_range(0, over));
            end
            FLAW_PAD: begin
                k = $urandom_range(0, plen - 1);
                frame_q[k] = frame_q[k] ^ 8'($urandom_range(1, 255));
            end
            FLAW_TRUNC: begin
                k = $urandom_range(1, frame_q.size() - 1);
                while (frame_q.size() > k)
                    void'(frame_q.pop_back());
            end
            default: ;
        endcase
    endtask

    task pick_settings(input int phase_no);
        logic [31:0] pat;
        if (phase_no == 0) begin
            write_reg(CFG_PAD_LENGTH, 32'd4);
            write_reg(CFG_PAD_PATTERN, 32'hFFFF_FFFF);
            write_reg(CFG_HEADER_LENGTH, 32'd4);
            write_reg(CFG_CHECK_LENGTH, 32'd4);
            write_reg(CFG_EOH_BYTE, 32'hFF);
            write_reg(CFG_EOP_BYTE, 32'hFF);
        end else if (phase_no == 1) begin
            // zero lengths behave as one
            write_reg(CFG_PAD_LENGTH, 32'd0);
            write_reg(CFG_PAD_PATTERN, 32'd0);
            write_reg(CFG_HEADER_LENGTH, 32'd0);
            write_reg(CFG_CHECK_LENGTH, 32'd0);
            write_reg(CFG_EOH_BYTE, 32'd0);
            write_reg(CFG_EOP_BYTE, 32'd0);
        end else begin
            case ($urandom_range(0, 3))
                0:       pat = '0;
                1:       pat = 32'hFFFF_FFFF;
                default: pat = $urandom;
            endcase
            if ($urandom_range(0, 1))
                write_reg(CFG_PAD_LENGTH, $urandom_range(0, 7));
            if ($urandom_range(0, 1))
                write_reg(CFG_PAD_PATTERN, pat);
            if ($urandom_range(0, 1))
                write_reg(CFG_HEADER_LENGTH, $urandom_range(0, 7));
            if ($urandom_range(0, 1))
                write_reg(CFG_CHECK_LENGTH, $urandom_range(0, 7));
            if ($urandom_range(0, 1))
                write_reg(CFG_EOH_BYTE, $urandom_range(0, 2) == 0 ? 32'hFF : $urandom_range(0, 255));
            if ($urandom_range(0, 1))
                write_reg(CFG_EOP_BYTE, $urandom_range(0, 2) == 0 ? 32'h00 : $urandom_range(0, 255));
        end
    endtask

    initial begin
        int phase_end, target, r, n;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: two zero pad bytes, two header bytes, two check bytes, zero markers
        calm = 1'b1;
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'd8);
        make_frame(1, FLAW_NONE);
        send_frame();
        make_frame(2, FLAW_EOH);
        send_frame();
        make_frame(1, FLAW_EOP);
        send_frame();

        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            pause_until_empty();
            pick_settings(settings_used);
            settings_used++;
            calm = ($urandom_range(0, 3) == 0);
            phase_end = items_sent + $urandom_range(60, 160);
            if (phase_end > target)
                phase_end = target;
            while (items_sent < phase_end) begin
                r = $urandom_range(0, 99);
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 240) : $urandom_range(1, 8);
                if (r < 65) begin
                    make_frame(n, FLAW_NONE);
                    send_frame();
                end else if (r < 82) begin
                    make_frame(n, t_flaw'($urandom_range(1, 6)));
                    send_frame();
                end else begin
                    repeat ($urandom_range(1, 6))
                        send_byte($urandom_range(0, 1) ? 8'($urandom)
                                  : sb.pad_pat[8 * $urandom_range(0, 3) +: 8]);
                end
            end
            // leave a frame half done across the next register writes
            if ($urandom_range(0, 1)) begin
                make_frame($urandom_range(1, 8), FLAW_TRUNC);
                send_frame();
            end
        end

        pause_until_empty();
        repeat (2 * DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending_q.size() != 0)
            sb.report_mismatch("results still outstanding", sb.pending_q.size(), 0);
        $display("Checked %0d bytes over %0d settings and %0d register writes",
                 sb.bytes_seen, settings_used + 1, sb.cfg_writes);
        $display("Frames: %0d good, %0d bad CRC, %0d aborted hunts; %0d mismatches",
                 sb.frames_good, sb.frames_bad, sb.aborts, sb.errors);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
